[rtl/rcc_pkg.sv]
// rcc_pkg: shared widths, register indexes and beat types of the emboss filter
// depends on nothing; imported by every module of the block
`default_nettype none

package rcc_pkg;

    // frame limits and derived widths
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // reset dimensions, held as last column and last row
    localparam logic [COL_W-1:0] RST_COL_LAST = COL_W'(639);
    localparam logic [ROW_W-1:0] RST_ROW_LAST = ROW_W'(479);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // one line-store entry: older row above newer row
    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_pix             pix;
        logic             last;
    } t_result;

    // results handed to the output queue in one cycle, first in order first
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

`default_nettype wire

[rtl/rcc_line_ram.sv]
// rcc_line_ram: both line stores in one synchronous ram, one write and one read port
// depends on rcc_pkg for the depth and entry type
`default_nettype none

module rcc_line_ram
    import rcc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [COL_W-1:0] i_waddr,
    input  wire t_line            i_wdata,
    input  wire logic             i_re,
    input  wire logic [COL_W-1:0] i_raddr,
    output t_line                 o_rdata
);

    t_line mem [MAX_WIDTH];
    t_line r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/rcc_emboss.sv]
// rcc_emboss: emboss kernel on one neighbourhood, all three channels, clamped to 0..255
// depends on rcc_pkg for the pixel type
`default_nettype none

module rcc_emboss
    import rcc_pkg::*;
(
    input  wire t_pix i_up_left,
    input  wire t_pix i_up,
    input  wire t_pix i_left,
    input  wire t_pix i_centre,
    input  wire t_pix i_right,
    input  wire t_pix i_down,
    input  wire t_pix i_down_right,
    output t_pix      o_pix
);

    // kernel -2 -1 0 / -1 1 1 / 0 1 2: positive and negative halves, then clamp
    function automatic logic [7:0] emboss_chan(
        input logic [7:0] ul, input logic [7:0] u, input logic [7:0] l,
        input logic [7:0] ce, input logic [7:0] ri, input logic [7:0] dn,
        input logic [7:0] dr);
        logic [10:0] pos;
        logic [10:0] neg;
        logic [10:0] diff;
        pos  = 11'(ce) + 11'(ri) + 11'(dn) + {2'b00, dr, 1'b0};
        neg  = {2'b00, ul, 1'b0} + 11'(u) + 11'(l);
        diff = pos - neg;
        if (pos < neg) begin
            return 8'd0;
        end else if (diff > 11'd255) begin
            return 8'd255;
        end else begin
            return diff[7:0];
        end
    endfunction

    assign o_pix.red   = emboss_chan(i_up_left.red, i_up.red, i_left.red, i_centre.red,
                                     i_right.red, i_down.red, i_down_right.red);
    assign o_pix.green = emboss_chan(i_up_left.green, i_up.green, i_left.green,
                                     i_centre.green, i_right.green, i_down.green,
                                     i_down_right.green);
    assign o_pix.blue  = emboss_chan(i_up_left.blue, i_up.blue, i_left.blue, i_centre.blue,
                                     i_right.blue, i_down.blue, i_down_right.blue);

endmodule

`default_nettype wire

[rtl/rcc_out_fifo.sv]
// rcc_out_fifo: four-entry result queue, up to two pushes and one pop per cycle
// depends on rcc_pkg for the result and push types
`default_nettype none

module rcc_out_fifo
    import rcc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output t_result    o_data,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [2:0] o_count
);

    t_result    r_mem [4];
    logic [1:0] r_wptr, n_wptr;
    logic [1:0] r_rptr, n_rptr;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign pop     = (r_count != 3'd0) && i_ready;
    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    // pointer and fill bookkeeping
    always_comb begin
        n_wptr  = r_wptr + i_push.count;
        n_rptr  = r_rptr + 2'(pop);
        n_count = r_count + 3'(i_push.count) - 3'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 2'd0;
            r_rptr  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wptr + 2'd1] <= i_push.second;
        end
    end

endmodule

`default_nettype wire

[rtl/rgb_3x3_convolution_clamped_unit.sv]
// rgb_3x3_convolution_clamped_unit: streaming 3x3 emboss filter with border pass-through
// a pixel is taken each cycle unless stage 1 stalls for output queue room
// throughput: 1 pixel per cycle, bounded by 1 result beat per cycle at the output queue,
//   so a pixel that makes two results costs two beats of output bandwidth
// line stores sit in one ram read at the pixel's column, written back as stage 1 moves on
// reset clears counters, window and queue and sets a 640 x 480 frame; no ram clearing pass
`default_nettype none

module rgb_3x3_convolution_clamped_unit
    import rcc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // pixel input
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_in_red,
    input  wire logic [7:0]           i_in_green,
    input  wire logic [7:0]           i_in_blue,
    // result output
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [ROW_W-1:0]          o_out_row,
    output logic [COL_W-1:0]          o_out_col,
    output logic [7:0]                o_out_red,
    output logic [7:0]                o_out_green,
    output logic [7:0]                o_out_blue,
    output logic                      o_last_of_item,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data
);

    // dimension register value to last index, 0 acting as 1 and clamped at the maximum
    function automatic logic [COL_W-1:0] col_last(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (v > DIM_W'(MAX_WIDTH)) begin
            return COL_W'(MAX_WIDTH - 1);
        end else begin
            return COL_W'(v - DIM_W'(1));
        end
    endfunction

    function automatic logic [ROW_W-1:0] row_last(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (v > DIM_W'(MAX_HEIGHT)) begin
            return ROW_W'(MAX_HEIGHT - 1);
        end else begin
            return ROW_W'(v - DIM_W'(1));
        end
    endfunction

    logic [COL_W-1:0] r_col_last;
    logic [ROW_W-1:0] r_row_last;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic             cfg_we;
    logic             in_acc;

    // stage 1: pixel waiting for its line-store read
    logic             r_s1_valid;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;
    t_pix             r_s1_pix;
    logic             r_s1_inner;
    logic             r_s1_border;
    logic             s1_adv;

    // forwarding of a write-back that lands on the entry being read
    logic             r_fwd;
    t_line            r_fwd_line;
    t_line            ram_q;
    t_line            line_q;
    t_line            line_wb;

    t_pix             r_win [6];
    t_pix             emb_pix;
    t_push            push;
    t_result          fifo_q;
    logic [2:0]       fifo_count;

    assign cfg_we      = i_cfg_valid;
    assign o_cfg_ready = 1'b1;

    // stage 1 moves on only when the queue has room for two results
    assign s1_adv     = r_s1_valid && (fifo_count <= 3'd2);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // position of the incoming pixel, restarting if it lies beyond the frame
    always_comb begin
        if ((r_col > r_col_last) || (r_row > r_row_last)) begin
            col_cur = '0;
            row_cur = '0;
        end else begin
            col_cur = r_col;
            row_cur = r_row;
        end
        n_col = col_cur + COL_W'(1);
        n_row = row_cur;
        if (col_cur == r_col_last) begin
            n_col = '0;
            n_row = (row_cur == r_row_last) ? '0 : row_cur + ROW_W'(1);
        end
    end

    // frame size and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= RST_COL_LAST;
            r_row_last <= RST_ROW_LAST;
            r_col      <= '0;
            r_row      <= '0;
        end else if (cfg_we) begin
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                r_col_last <= col_last(i_cfg_data);
                r_col      <= '0;
                r_row      <= '0;
            end else if (i_cfg_index == REG_FRAME_HEIGHT) begin
                r_row_last <= row_last(i_cfg_data);
                r_col      <= '0;
                r_row      <= '0;
            end
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_adv && (r_s1_col == col_cur);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row    <= row_cur;
            r_s1_col    <= col_cur;
            r_s1_pix    <= '{red: i_in_red, green: i_in_green, blue: i_in_blue};
            r_s1_inner  <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
            r_s1_border <= (row_cur == '0) || (row_cur == r_row_last)
                        || (col_cur == '0) || (col_cur == r_col_last);
            r_fwd_line  <= line_wb;
        end
    end

    // line stores: read at acceptance, written back when stage 1 moves on
    assign line_q  = r_fwd ? r_fwd_line : ram_q;
    assign line_wb = '{older: line_q.newer, newer: r_s1_pix};

    rcc_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (line_wb),
        .i_re    (in_acc),
        .i_raddr (col_cur),
        .o_rdata (ram_q)
    );

    // window: slots 0..2 hold column c-1 rows r-2..r, slots 3..5 column c-2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_adv) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= line_q.older;
            r_win[1] <= line_q.newer;
            r_win[2] <= r_s1_pix;
        end
    end

    rcc_emboss u_emboss (
        .i_up_left    (r_win[3]),
        .i_up         (r_win[0]),
        .i_left       (r_win[4]),
        .i_centre     (r_win[1]),
        .i_right      (line_q.newer),
        .i_down       (r_win[2]),
        .i_down_right (r_s1_pix),
        .o_pix        (emb_pix)
    );

    // results of this pixel: filtered interior one first, then the border pass-through
    always_comb begin
        push.first  = '{row: r_s1_row - ROW_W'(1), col: r_s1_col - COL_W'(1),
                        pix: emb_pix, last: !r_s1_border};
        push.second = '{row: r_s1_row, col: r_s1_col, pix: r_s1_pix, last: 1'b1};
        push.count  = 2'd0;
        if (s1_adv) begin
            if (r_s1_inner && r_s1_border) begin
                push.count = 2'd2;
            end else if (r_s1_inner) begin
                push.count = 2'd1;
            end else if (r_s1_border) begin
                push.count = 2'd1;
                push.first = push.second;
            end
        end
    end

    rcc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_data  (fifo_q),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_count (fifo_count)
    );

    assign o_out_row      = fifo_q.row;
    assign o_out_col      = fifo_q.col;
    assign o_out_red      = fifo_q.pix.red;
    assign o_out_green    = fifo_q.pix.green;
    assign o_out_blue     = fifo_q.pix.blue;
    assign o_last_of_item = fifo_q.last;

    // the queue never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= 3'd4)
        else $error("output queue over four entries");

    // a stalled stage 1 stays valid and keeps its column for the write-back
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_col)))
        else $error("stage 1 lost a stalled pixel");

    // an accepted pixel always occupies stage 1 next cycle
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_we) |=> r_s1_valid)
        else $error("accepted pixel missing from stage 1");

endmodule

`default_nettype wire
